[src/rcfe_pkg.sv]
// rcfe_pkg: shared constants, register codes and types for the RC channel frame encoder.
// No dependencies; every other file of the block imports this package.
package rcfe_pkg;

	// Frame geometry
	localparam int CHANNEL_COUNT   = 16;
	localparam int CHANNEL_BITS    = 11;
	localparam int INPUT_CHANNELS  = 8;
	localparam int SAMPLE_W        = 16;
	localparam int HEADER_BYTES    = 4;
	localparam int CHAN_TOTAL_BITS = CHANNEL_COUNT * CHANNEL_BITS;
	localparam int CHAN_BYTES      = CHAN_TOTAL_BITS / 8;
	localparam int FRAME_BYTES     = HEADER_BYTES + CHAN_BYTES;
	localparam int FRAME_BITS      = 8 * FRAME_BYTES;
	localparam int CNT_W           = $clog2(FRAME_BYTES + 1);

	// Channel scaling: code = floor(v * 800 / 1000) + 1024, clipped to 2047
	localparam int SCALE_NUM      = 800;
	localparam int SCALE_DEN      = 1000;
	localparam int CHANNEL_CENTER = 1024;
	localparam int CHANNEL_MAX    = 2047;
	localparam int FIXED_SAMPLE   = 42;
	localparam int FIXED_CODE     = CHANNEL_CENTER + FIXED_SAMPLE * SCALE_NUM / SCALE_DEN;
	// smallest sample whose scaled value reaches the clip point
	localparam int SAT_LIMIT      = ((CHANNEL_MAX + 1 - CHANNEL_CENTER) * SCALE_DEN
		+ SCALE_NUM - 1) / SCALE_NUM;
	// below SAT_LIMIT: floor(4v/5) == (v * 4 * 6554) >> 15, exact for 4v < 2^14
	localparam int SCALE_SHIFT    = 15;
	localparam int SCALE_MUL      = 4 * (((1 << SCALE_SHIFT) + 4) / 5);
	localparam int SCALE_MUL_W    = 15;
	localparam int SCALE_IN_W     = 11;
	localparam int PROD_W         = SCALE_IN_W + SCALE_MUL_W;

	// Header bytes
	localparam logic [7:0] HDR_LOW_PROTO  = 8'h55;
	localparam logic [7:0] HDR_HIGH_PROTO = 8'h54;
	localparam int         PROTO_SPLIT    = 32;

	// Input item modes
	localparam logic MODE_BIND  = 1'b0;
	localparam logic MODE_FRAME = 1'b1;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 3;
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PROTOCOL_NUMBER = 3'd0,
		REG_RANGE_CHECK     = 3'd1,
		REG_AUTOBIND_EN     = 3'd2,
		REG_RECEIVER_NUMBER = 3'd3,
		REG_PROTO_VARIANT   = 3'd4,
		REG_REDUCED_POWER   = 3'd5,
		REG_PROTOCOL_OPTION = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [5:0] protocol_number;
		logic       range_check;
		logic       autobind_en;
		logic [3:0] receiver_number;
		logic [2:0] proto_variant;
		logic       reduced_power;
		logic [7:0] protocol_option;
	} cfg_t;

	typedef logic [CHANNEL_BITS-1:0] chan_code_t;

	// Frame source handed from the input stage to the serializer
	typedef struct packed {
		logic [HEADER_BYTES-1:0][7:0]  hdr;
		chan_code_t [INPUT_CHANNELS-1:0] chan;
	} frame_src_t;

endpackage

[src/rcfe_if.sv]
// Handshake interfaces for the RC channel frame encoder: sample input, byte output, config.
// Depends on rcfe_pkg for field widths.
interface rcfe_in_if import rcfe_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                mode;
	logic [SAMPLE_W-1:0] chan0;
	logic [SAMPLE_W-1:0] chan1;
	logic [SAMPLE_W-1:0] chan2;
	logic [SAMPLE_W-1:0] chan3;
	logic [SAMPLE_W-1:0] chan4;
	logic [SAMPLE_W-1:0] chan5;
	logic [SAMPLE_W-1:0] chan6;
	logic [SAMPLE_W-1:0] chan7;

	modport source (output valid, mode, chan0, chan1, chan2, chan3, chan4, chan5, chan6,
		chan7, input ready);
	modport sink (input valid, mode, chan0, chan1, chan2, chan3, chan4, chan5, chan6,
		chan7, output ready);
endinterface

interface rcfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, frame_byte, last_byte, input ready);
	modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

interface rcfe_cfg_if import rcfe_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [7:0]            data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

[src/rcfe_cfg_regs.sv]
// rcfe_cfg_regs: configuration register file written over the config channel.
// Depends on rcfe_pkg (cfg_t, register indexes) and rcfe_if (rcfe_cfg_if).
module rcfe_cfg_regs import rcfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rcfe_cfg_if.sink   cfg,
	output cfg_t       regs
);

	cfg_t regs_q;
	logic wr_en;

	// writes never stall
	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid && cfg.ready;
	assign regs      = regs_q;

	// register write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(cfg.addr))
				REG_PROTOCOL_NUMBER: regs_q.protocol_number <= cfg.data[5:0];
				REG_RANGE_CHECK:     regs_q.range_check     <= cfg.data[0];
				REG_AUTOBIND_EN:     regs_q.autobind_en     <= cfg.data[0];
				REG_RECEIVER_NUMBER: regs_q.receiver_number <= cfg.data[3:0];
				REG_PROTO_VARIANT:   regs_q.proto_variant   <= cfg.data[2:0];
				REG_REDUCED_POWER:   regs_q.reduced_power   <= cfg.data[0];
				REG_PROTOCOL_OPTION: regs_q.protocol_option <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

[src/rcfe_scale.sv]
// rcfe_scale: one channel lane, sample to 11-bit code (x0.8, offset 1024, clipped).
// Depends on rcfe_pkg for scaling constants.
module rcfe_scale import rcfe_pkg::*; (
	input  logic [SAMPLE_W-1:0] sample,
	output chan_code_t          code
);

	logic [PROD_W-1:0] prod;
	logic              sat;

	// reciprocal multiply replaces the divide by 5; valid below the clip point
	assign prod = PROD_W'(sample[SCALE_IN_W-1:0]) * PROD_W'(SCALE_MUL);
	assign sat  = sample >= SAMPLE_W'(SAT_LIMIT);

	assign code = sat ? CHANNEL_BITS'(CHANNEL_MAX)
		: CHANNEL_BITS'(CHANNEL_CENTER) + prod[SCALE_SHIFT +: CHANNEL_BITS];

endmodule

[src/rcfe_serializer.sv]
// rcfe_serializer: packs header and channel codes into a frame register and shifts out bytes.
// Depends on rcfe_pkg (frame geometry, frame_src_t) and rcfe_if (rcfe_out_if).
module rcfe_serializer import rcfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	input  frame_src_t src,
	output logic       src_take,
	rcfe_out_if.source frame_out
);

	logic [FRAME_BITS-1:0]      shreg_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       out_valid_q;
	logic [7:0]                 byte_q;
	logic                       last_q;
	logic                       adv;
	logic [CHAN_TOTAL_BITS-1:0] chan_bits;
	logic [FRAME_BITS-1:0]      frame_bits;

	// one byte moves to the output register when it is empty or being drained
	assign adv      = (cnt_q != '0) && (!out_valid_q || frame_out.ready);
	// load next frame when idle or while the current last byte leaves
	assign src_take = src_valid && ((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && adv));

	// channel packing, LSB first; the channel bits fill whole bytes, so none is dropped
	always_comb begin
		chan_bits = '0;
		for (int k = 0; k < INPUT_CHANNELS; k++) begin
			chan_bits[k*CHANNEL_BITS +: CHANNEL_BITS] = src.chan[k];
		end
		for (int k = INPUT_CHANNELS; k < CHANNEL_COUNT; k++) begin
			chan_bits[k*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(FIXED_CODE);
		end
		frame_bits = {chan_bits[8*CHAN_BYTES-1:0], src.hdr};
	end

	// control: byte counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (src_take) begin
				cnt_q <= CNT_W'(FRAME_BYTES);
			end else if (adv) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (frame_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: frame shift register and output byte
	always_ff @(posedge clk) begin
		if (src_take) begin
			shreg_q <= frame_bits;
		end else if (adv) begin
			shreg_q <= shreg_q >> 8;
		end
		if (adv) begin
			byte_q <= shreg_q[7:0];
			last_q <= cnt_q == CNT_W'(1);
		end
	end

	assign frame_out.valid      = out_valid_q;
	assign frame_out.frame_byte = byte_q;
	assign frame_out.last_byte  = last_q;

	// a last byte on the output means the frame counter ran out or was reloaded
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> (cnt_q == '0) || (cnt_q == CNT_W'(FRAME_BYTES)))
		else $error("last byte shown while frame still has bytes");

	// a stalled output freezes the byte counter unless a new frame loads
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !frame_out.ready && !src_take |=> $stable(cnt_q))
		else $error("byte counter moved while output stalled");

	// a frame is only loaded when no byte of the previous one remains unsent
	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		src_take |-> (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && adv))
		else $error("frame loaded over unsent bytes");

endmodule

[src/rc_channel_frame_encoder_unit.sv]
// rc_channel_frame_encoder_unit: top level, input stage, bind flag, scaling lanes, serializer.
// A frame item passes the input stage register and the frame shift register; its first byte
// then shows in the output byte register. Frames of 26 bytes leave at one byte per cycle while
// frame_out.ready holds; the byte serializer sets that rate. Bind requests emit nothing.
// Reset (arst_n low, asynchronous): config registers, bind flag and all valids clear.
// Depends on rcfe_pkg, rcfe_if, rcfe_cfg_regs, rcfe_scale and rcfe_serializer.
module rc_channel_frame_encoder_unit import rcfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rcfe_in_if.sink    sample_in,
	rcfe_out_if.source frame_out,
	rcfe_cfg_if.sink   cfg
);

	cfg_t                                regs;
	logic                                accept;
	logic                                bind_pending_q;
	logic                                src_valid_s1;
	logic                                src_take;
	logic [HEADER_BYTES-1:0][7:0]        hdr;
	logic [HEADER_BYTES-1:0][7:0]        hdr_s1;
	logic [INPUT_CHANNELS-1:0][SAMPLE_W-1:0] samples;
	logic [INPUT_CHANNELS-1:0][SAMPLE_W-1:0] samples_s1;
	frame_src_t                          src;

	rcfe_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// input transaction
	assign sample_in.ready = !src_valid_s1 || src_take;
	assign accept          = sample_in.valid && sample_in.ready;

	assign samples = {sample_in.chan7, sample_in.chan6, sample_in.chan5, sample_in.chan4,
		sample_in.chan3, sample_in.chan2, sample_in.chan1, sample_in.chan0};

	// header bytes, captured with the bind flag at acceptance
	always_comb begin
		hdr[0] = (regs.protocol_number < 6'(PROTO_SPLIT)) ? HDR_LOW_PROTO : HDR_HIGH_PROTO;
		hdr[1] = {bind_pending_q, regs.autobind_en, regs.range_check,
			regs.protocol_number[4:0]};
		hdr[2] = {regs.reduced_power, regs.proto_variant, regs.receiver_number};
		hdr[3] = regs.protocol_option;
	end

	// control: stage valid and pending bind flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid_s1   <= 1'b0;
			bind_pending_q <= 1'b0;
		end else begin
			if (accept && (sample_in.mode == MODE_FRAME)) begin
				src_valid_s1 <= 1'b1;
			end else if (src_take) begin
				src_valid_s1 <= 1'b0;
			end
			if (accept) begin
				bind_pending_q <= (sample_in.mode == MODE_BIND);
			end
		end
	end

	// payload of the input stage
	always_ff @(posedge clk) begin
		if (accept && (sample_in.mode == MODE_FRAME)) begin
			hdr_s1     <= hdr;
			samples_s1 <= samples;
		end
	end

	// scaling lanes, results registered by the serializer on load
	for (genvar k = 0; k < INPUT_CHANNELS; k++) begin : g_lane
		rcfe_scale u_scale (
			.sample (samples_s1[k]),
			.code   (src.chan[k])
		);
	end

	assign src.hdr = hdr_s1;

	rcfe_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid_s1),
		.src       (src),
		.src_take  (src_take),
		.frame_out (frame_out)
	);

endmodule

[dv/rc_channel_frame_encoder_unit_tb.sv]
// Self-checking testbench for rc_channel_frame_encoder_unit: frame bytes are predicted
// per accepted transaction and compared in order. Needs rcfe_pkg and the rcfe_if interfaces.
`timescale 1ns / 1ps

module rc_channel_frame_encoder_unit_tb import rcfe_pkg::*; ();

	typedef logic [INPUT_CHANNELS-1:0][SAMPLE_W-1:0] samples_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	// address past the register list, writes to it must be dropped
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

	// Holds the register image, bind flag and the bytes still due from the block
	class frame_scoreboard;
		cfg_t        regs;
		logic        bind_armed;
		frame_byte_t due_bytes[$];
		int          errors;

		function new();
			regs       = '0;
			bind_armed = 1'b0;
			errors     = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [7:0] data);
			case (addr)
				REG_PROTOCOL_NUMBER: regs.protocol_number = data[5:0];
				REG_RANGE_CHECK:     regs.range_check     = data[0];
				REG_AUTOBIND_EN:     regs.autobind_en     = data[0];
				REG_RECEIVER_NUMBER: regs.receiver_number = data[3:0];
				REG_PROTO_VARIANT:   regs.proto_variant   = data[2:0];
				REG_REDUCED_POWER:   regs.reduced_power   = data[0];
				REG_PROTOCOL_OPTION: regs.protocol_option = data;
				default: ;
			endcase
		endfunction

		// floor(v * 4/5) + center, clipped at the top code
		function chan_code_t scale_sample(logic [SAMPLE_W-1:0] sample);
			int unsigned v;
			v = sample;
			v = v * SCALE_NUM / SCALE_DEN + CHANNEL_CENTER;
			if (v > CHANNEL_MAX)
				v = CHANNEL_MAX;
			return chan_code_t'(v);
		endfunction

		function void note_item(logic mode, samples_t samples);
			logic [CHAN_TOTAL_BITS-1:0] packed_chans;
			logic [7:0]                 frame [FRAME_BYTES];
			logic [SAMPLE_W-1:0]        sample;
			frame_byte_t                fb;
			if (mode == MODE_BIND) begin
				bind_armed = 1'b1;
				return;
			end
			frame[0] = (regs.protocol_number < PROTO_SPLIT) ? HDR_LOW_PROTO : HDR_HIGH_PROTO;
			frame[1] = {bind_armed, regs.autobind_en, regs.range_check,
				regs.protocol_number[4:0]};
			frame[2] = {regs.reduced_power, regs.proto_variant, regs.receiver_number};
			frame[3] = regs.protocol_option;
			// channels packed LSB first, upper channels carry the fixed sample
			for (int k = 0; k < CHANNEL_COUNT; k++) begin
				sample = (k < INPUT_CHANNELS) ? samples[k] : SAMPLE_W'(FIXED_SAMPLE);
				packed_chans[k*CHANNEL_BITS +: CHANNEL_BITS] = scale_sample(sample);
			end
			for (int i = 0; i < CHAN_BYTES; i++)
				frame[HEADER_BYTES + i] = packed_chans[8*i +: 8];
			for (int i = 0; i < FRAME_BYTES; i++) begin
				fb.data = frame[i];
				fb.last = (i == FRAME_BYTES - 1);
				due_bytes.push_back(fb);
			end
			bind_armed = 1'b0;
		endfunction

		task check_byte(logic [7:0] data, logic last);
			frame_byte_t fb;
			if (due_bytes.size() == 0) begin
				report($sformatf("byte %02h last=%0b with nothing due", data, last));
				return;
			end
			fb = due_bytes.pop_front();
			if (data !== fb.data)
				report($sformatf("frame_byte %02h, want %02h", data, fb.data));
			if (last !== fb.last)
				report($sformatf("last_byte %0b, want %0b (byte %02h)", last, fb.last, data));
		endtask

		function int pending();
			return due_bytes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic gaps_on;

	rcfe_in_if  sample_in();
	rcfe_out_if frame_out();
	rcfe_cfg_if cfg();

	frame_scoreboard sb = new();

	rc_channel_frame_encoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (sample_in),
		.frame_out (frame_out),
		.cfg       (cfg)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Monitors: every transaction is taken at the rising edge
	always @(posedge clk) begin
		if (arst_n && cfg.valid && cfg.ready)
			sb.write_reg(cfg.addr, cfg.data);
		if (arst_n && sample_in.valid && sample_in.ready)
			sb.note_item(sample_in.mode, {sample_in.chan7, sample_in.chan6, sample_in.chan5,
				sample_in.chan4, sample_in.chan3, sample_in.chan2, sample_in.chan1,
				sample_in.chan0});
		if (arst_n && frame_out.valid && frame_out.ready)
			sb.check_byte(frame_out.frame_byte, frame_out.last_byte);
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(20, 40);
	endfunction

	// Output backpressure
	initial begin
		int stall_left;
		stall_left = 0;
		frame_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				frame_out.ready = 1'b0;
				stall_left--;
			end else begin
				frame_out.ready = 1'b1;
				if (gaps_on && $urandom_range(0, 3) == 0)
					stall_left = gap_len();
			end
		end
	end

	// Called at a falling edge, returns at a falling edge
	task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [7:0] data);
		cfg.addr  = addr;
		cfg.data  = data;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// valid stays up after a transaction so back-to-back items are possible
	task automatic send_item(logic mode, samples_t samples);
		int gap;
		gap = (gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			sample_in.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_in.mode  = mode;
		sample_in.chan0 = samples[0];
		sample_in.chan1 = samples[1];
		sample_in.chan2 = samples[2];
		sample_in.chan3 = samples[3];
		sample_in.chan4 = samples[4];
		sample_in.chan5 = samples[5];
		sample_in.chan6 = samples[6];
		sample_in.chan7 = samples[7];
		sample_in.valid = 1'b1;
		do @(posedge clk); while (!sample_in.ready);
		@(negedge clk);
	endtask

	// Drain all due bytes; a trailing bind request may still be in flight after that
	task automatic wait_idle();
		sample_in.valid = 1'b0;
		while (sb.pending() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0, 1, 2: return SAMPLE_W'($urandom);
			3, 4, 5: return SAMPLE_W'($urandom_range(0, SAT_LIMIT - 1));
			6, 7:    return SAMPLE_W'($urandom_range(SAT_LIMIT - 10, SAT_LIMIT + 10));
			8:       return '0;
			default: return '1;
		endcase
	endfunction

	task automatic send_random_item();
		samples_t s;
		for (int k = 0; k < INPUT_CHANNELS; k++)
			s[k] = rand_sample();
		send_item(($urandom_range(0, 4) == 0) ? MODE_BIND : MODE_FRAME, s);
	endtask

	function automatic logic [7:0] rand_reg_value();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Some registers keep their value from the last phase
	task automatic random_config();
		if ($urandom_range(0, 3) != 0) cfg_write(REG_PROTOCOL_NUMBER, rand_reg_value());
		if ($urandom_range(0, 3) != 0) cfg_write(REG_RANGE_CHECK, rand_reg_value());
		if ($urandom_range(0, 3) != 0) cfg_write(REG_AUTOBIND_EN, rand_reg_value());
		if ($urandom_range(0, 3) != 0) cfg_write(REG_RECEIVER_NUMBER, rand_reg_value());
		if ($urandom_range(0, 3) != 0) cfg_write(REG_PROTO_VARIANT, rand_reg_value());
		if ($urandom_range(0, 3) != 0) cfg_write(REG_REDUCED_POWER, rand_reg_value());
		if ($urandom_range(0, 3) != 0) cfg_write(REG_PROTOCOL_OPTION, rand_reg_value());
		if ($urandom_range(0, 2) == 0) cfg_write(REG_UNUSED, rand_reg_value());
	endtask

	// Hard stop well past the slowest legal run
	initial begin
		#15_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Main sequence
	initial begin
		samples_t s;
		arst_n          = 1'b0;
		gaps_on         = 1'b1;
		sample_in.valid = 1'b0;
		sample_in.mode  = MODE_FRAME;
		sample_in.chan0 = '0;
		sample_in.chan1 = '0;
		sample_in.chan2 = '0;
		sample_in.chan3 = '0;
		sample_in.chan4 = '0;
		sample_in.chan5 = '0;
		sample_in.chan6 = '0;
		sample_in.chan7 = '0;
		cfg.valid       = 1'b0;
		cfg.addr        = REG_PROTOCOL_NUMBER;
		cfg.data        = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset config, extreme samples, clip boundary, bind handling
		send_item(MODE_FRAME, '0);
		send_item(MODE_FRAME, '1);
		s = {16'hFFFF, 16'd0, 16'd1, 16'd4, 16'd5, 16'd1278, 16'd1279, 16'd1280};
		send_item(MODE_FRAME, s);
		send_item(MODE_BIND, '0);
		send_item(MODE_FRAME, s);
		send_item(MODE_BIND, '1);
		send_item(MODE_BIND, '0);
		send_item(MODE_FRAME, '1);
		send_item(MODE_FRAME, s);
		wait_idle();

		// all registers at max, high data bits must be masked off
		cfg_write(REG_PROTOCOL_NUMBER, 8'hFF);
		cfg_write(REG_RANGE_CHECK, 8'hFF);
		cfg_write(REG_AUTOBIND_EN, 8'hFF);
		cfg_write(REG_RECEIVER_NUMBER, 8'hFF);
		cfg_write(REG_PROTO_VARIANT, 8'hFF);
		cfg_write(REG_REDUCED_POWER, 8'hFF);
		cfg_write(REG_PROTOCOL_OPTION, 8'hFF);
		cfg_write(REG_UNUSED, 8'h00);
		send_item(MODE_FRAME, s);
		send_item(MODE_BIND, s);
		send_item(MODE_FRAME, '0);
		wait_idle();

		// header split point
		cfg_write(REG_PROTOCOL_NUMBER, 8'd31);
		send_item(MODE_FRAME, s);
		wait_idle();
		cfg_write(REG_PROTOCOL_NUMBER, 8'd32);
		send_item(MODE_FRAME, s);
		wait_idle();
		cfg_write(REG_PROTOCOL_NUMBER, 8'h00);
		cfg_write(REG_PROTOCOL_OPTION, 8'h00);
		send_item(MODE_BIND, '0);
		send_item(MODE_FRAME, '1);
		wait_idle();

		// Random phases, every third one runs without gaps
		for (int p = 0; p < 10; p++) begin
			gaps_on = (p % 3 != 2);
			random_config();
			repeat (18) send_random_item();
			wait_idle();
		end

		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
